@@ rtl/tedec_pkg.sv @@
`default_nettype none

package tedec_pkg;

    // byte classes recognized by the front end
    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_BEL,
        CLS_SUB,
        CLS_ESC,
        CLS_EQ,
        CLS_LBRACK,
        CLS_ATTR_B,
        CLS_ATTR_C,
        CLS_DIGIT,
        CLS_SEMI,
        CLS_H,
        CLS_J,
        CLS_K
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] ch;
    } t_item;

    typedef enum logic [2:0] {
        ACT_CONSUMED  = 3'd0,
        ACT_PASS      = 3'd1,
        ACT_BELL      = 3'd2,
        ACT_CLEAR     = 3'd3,
        ACT_ERASE_EOL = 3'd4,
        ACT_CURSOR    = 3'd5,
        ACT_ACCENT    = 3'd6,
        ACT_NORMAL    = 3'd7
    } t_action;

    localparam logic [7:0] CHR_BEL    = 8'h07;
    localparam logic [7:0] CHR_SUB    = 8'd26;
    localparam logic [7:0] CHR_ESC    = 8'd27;
    localparam logic [7:0] CHR_EQ     = 8'h3D;
    localparam logic [7:0] CHR_LBRACK = 8'h5B;
    localparam logic [7:0] CHR_B      = 8'h42;
    localparam logic [7:0] CHR_C      = 8'h43;
    localparam logic [7:0] CHR_H      = 8'h48;
    localparam logic [7:0] CHR_J      = 8'h4A;
    localparam logic [7:0] CHR_K      = 8'h4B;
    localparam logic [7:0] CHR_SEMI   = 8'h3B;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CURSOR_BIAS = 8'd31;

endpackage

`default_nettype wire

@@ rtl/terminal_escape_decoder.sv @@
`default_nettype none
// Path: a byte accepted at the input passes the front register, then the queue, then the
//   output register of the sequencer. Throughput: one byte per cycle while the queue has
//   room; the sequencer handles one queued byte per cycle while the output is not stalled.
// Reset: synchronous, active low; clears the front register, the queue and the sequencer
//   state (idle phase, parameters zero); no result is valid after reset.

module terminal_escape_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [2:0]      o_action,
    output logic [7:0]      o_pass_char,
    output logic [7:0]      o_cursor_row,
    output logic [7:0]      o_cursor_col
);
    import tedec_pkg::*;

    // front to queue
    logic  wr_en;
    t_item wr_item;
    logic  q_full;

    // queue to sequencer
    logic  rd_en;
    t_item rd_item;
    logic  q_empty;

    // Front: take one byte per transaction and tag it with its class.
    tedec_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_char_in  (i_char_in),
        .o_wr_en    (wr_en),
        .o_wr_item  (wr_item),
        .i_q_full   (q_full)
    );

    // Short queue: let the front keep accepting while the output is stalled.
    tedec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_item (wr_item),
        .o_full    (q_full),
        .i_rd_en   (rd_en),
        .o_rd_item (rd_item),
        .o_empty   (q_empty)
    );

    // Back: run the escape sequence state machine and hold each command
    // in the output register until the downstream transaction completes.
    tedec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_item    (rd_item),
        .i_q_empty    (q_empty),
        .o_rd_en      (rd_en),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_action     (o_action),
        .o_pass_char  (o_pass_char),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

    // every accepted byte yields exactly one command, so the sequencer
    // must never pop a byte from an empty queue
    a_out_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> !q_empty)
        else $error("sequencer popped an empty queue");

endmodule

`default_nettype wire

@@ rtl/tedec_front.sv @@
`default_nettype none

module tedec_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [7:0]       i_char_in,
    output logic                  o_wr_en,
    output tedec_pkg::t_item      o_wr_item,
    input  wire logic             i_q_full
);
    import tedec_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_cls  cls;
    logic  accept;

    // classify the raw byte
    always_comb begin
        unique case (i_char_in) inside
            CHR_BEL:             cls = CLS_BEL;
            CHR_SUB:             cls = CLS_SUB;
            CHR_ESC:             cls = CLS_ESC;
            CHR_EQ:              cls = CLS_EQ;
            CHR_LBRACK:          cls = CLS_LBRACK;
            CHR_B:               cls = CLS_ATTR_B;
            CHR_C:               cls = CLS_ATTR_C;
            [CHR_ZERO:CHR_NINE]: cls = CLS_DIGIT;
            CHR_SEMI:            cls = CLS_SEMI;
            CHR_H:               cls = CLS_H;
            CHR_J:               cls = CLS_J;
            CHR_K:               cls = CLS_K;
            default:             cls = CLS_OTHER;
        endcase
    end

    assign o_wr_en    = r_valid && !i_q_full;
    assign o_in_ready = !r_valid || !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_wr_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_wr_en) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_item.cls <= cls;
            r_item.ch  <= i_char_in;
        end
    end

    // a held byte stays until the queue takes it
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_q_full) |=> (r_valid && $stable(r_item)))
        else $error("front dropped a held byte");
    a_class_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_item.cls == CLS_DIGIT) |->
        (r_item.ch >= CHR_ZERO && r_item.ch <= CHR_NINE))
        else $error("digit class on non-digit byte");

endmodule

`default_nettype wire

@@ rtl/tedec_queue.sv @@
`default_nettype none

module tedec_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire tedec_pkg::t_item i_wr_item,
    output logic                  o_full,
    input  wire logic             i_rd_en,
    output tedec_pkg::t_item      o_rd_item,
    output logic                  o_empty
);
    import tedec_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_rd_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_wr_en, i_rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> !o_full)
        else $error("queue write while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> !o_empty)
        else $error("queue read while empty");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr == r_rd_ptr) |-> (r_count == '0 || r_count == FULL_CNT))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ rtl/tedec_back.sv @@
`default_nettype none

module tedec_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tedec_pkg::t_item i_rd_item,
    input  wire logic             i_q_empty,
    output logic                  o_rd_en,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [2:0]            o_action,
    output logic [7:0]            o_pass_char,
    output logic [7:0]            o_cursor_row,
    output logic [7:0]            o_cursor_col
);
    import tedec_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_CSI,
        PH_ROW,
        PH_COL,
        PH_ATTR
    } t_phase;

    t_phase     r_phase,   n_phase;
    logic [7:0] r_row_byte, n_row_byte;
    logic [7:0] r_param_row, n_param_row;
    logic [7:0] r_param_col, n_param_col;
    logic       r_seen_sep, n_seen_sep;
    logic       r_seen_param, n_seen_param;

    logic       r_out_valid;
    t_action    r_action,  n_action;
    logic [7:0] r_pass_char, n_pass_char;
    logic [7:0] r_row,     n_row;
    logic [7:0] r_col,     n_col;

    logic       pop;
    logic [3:0] digit;

    function automatic logic [7:0] f_add_digit(input logic [7:0] acc, input logic [3:0] d);
        logic [11:0] v;
        v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'd0, d};
        return (v > 12'd255) ? 8'hFF : v[7:0];
    endfunction

    function automatic logic [7:0] f_at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    // take a byte whenever the output register is free or being drained
    assign pop   = !i_q_empty && (!r_out_valid || i_out_ready);
    assign digit = i_rd_item.ch[3:0];

    always_comb begin
        n_phase      = r_phase;
        n_row_byte   = r_row_byte;
        n_param_row  = r_param_row;
        n_param_col  = r_param_col;
        n_seen_sep   = r_seen_sep;
        n_seen_param = r_seen_param;
        n_action     = ACT_CONSUMED;
        n_pass_char  = 8'd0;
        n_row        = 8'd0;
        n_col        = 8'd0;
        unique case (r_phase)
            PH_ESC: begin
                unique case (i_rd_item.cls)
                    CLS_EQ:     n_phase = PH_ROW;
                    CLS_LBRACK: n_phase = PH_CSI;
                    CLS_ATTR_B: begin
                        n_action = ACT_ACCENT;
                        n_phase  = PH_ATTR;
                    end
                    CLS_ATTR_C: begin
                        n_action = ACT_NORMAL;
                        n_phase  = PH_ATTR;
                    end
                    default: begin
                        n_action    = ACT_PASS;
                        n_pass_char = i_rd_item.ch;
                        n_phase     = PH_IDLE;
                    end
                endcase
            end
            PH_ROW: begin
                n_row_byte = i_rd_item.ch;
                n_phase    = PH_COL;
            end
            PH_COL: begin
                n_action = ACT_CURSOR;
                n_row    = 8'(r_row_byte - CURSOR_BIAS);
                n_col    = 8'(i_rd_item.ch - CURSOR_BIAS);
                n_phase  = PH_IDLE;
            end
            PH_CSI: begin
                unique case (i_rd_item.cls)
                    CLS_DIGIT: begin
                        if (r_seen_sep) begin
                            n_param_col = f_add_digit(r_param_col, digit);
                        end else begin
                            n_param_row = f_add_digit(r_param_row, digit);
                        end
                        n_seen_param = 1'b1;
                    end
                    CLS_SEMI: n_seen_sep = 1'b1;
                    CLS_H: begin
                        n_action = ACT_CURSOR;
                        // no parameters at all means home
                        if (r_seen_param || r_seen_sep) begin
                            n_row = f_at_least_one(r_param_row);
                            n_col = f_at_least_one(r_param_col);
                        end else begin
                            n_row = 8'd1;
                            n_col = 8'd1;
                        end
                        n_phase = PH_IDLE;
                    end
                    CLS_J: begin
                        n_action = ACT_CLEAR;
                        n_phase  = PH_IDLE;
                    end
                    CLS_K: begin
                        n_action = ACT_ERASE_EOL;
                        n_phase  = PH_IDLE;
                    end
                    default: begin
                        n_action    = ACT_PASS;
                        n_pass_char = i_rd_item.ch;
                        n_phase     = PH_IDLE;
                    end
                endcase
            end
            PH_ATTR: n_phase = PH_IDLE;
            default: begin
                n_phase = PH_IDLE;
                unique case (i_rd_item.cls)
                    CLS_BEL: n_action = ACT_BELL;
                    CLS_SUB: n_action = ACT_CLEAR;
                    CLS_ESC: begin
                        n_phase      = PH_ESC;
                        n_row_byte   = 8'd0;
                        n_param_row  = 8'd0;
                        n_param_col  = 8'd0;
                        n_seen_sep   = 1'b0;
                        n_seen_param = 1'b0;
                    end
                    default: begin
                        n_action    = ACT_PASS;
                        n_pass_char = i_rd_item.ch;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_row_byte   <= 8'd0;
            r_param_row  <= 8'd0;
            r_param_col  <= 8'd0;
            r_seen_sep   <= 1'b0;
            r_seen_param <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop) begin
                r_phase      <= n_phase;
                r_row_byte   <= n_row_byte;
                r_param_row  <= n_param_row;
                r_param_col  <= n_param_col;
                r_seen_sep   <= n_seen_sep;
                r_seen_param <= n_seen_param;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
        if (pop) begin
            r_action    <= n_action;
            r_pass_char <= n_pass_char;
            r_row       <= n_row;
            r_col       <= n_col;
        end
    end

    assign o_rd_en      = pop;
    assign o_out_valid  = r_out_valid;
    assign o_action     = r_action;
    assign o_pass_char  = r_pass_char;
    assign o_cursor_row = r_row;
    assign o_cursor_col = r_col;

    a_pass_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_action != ACT_PASS) |-> (r_pass_char == 8'd0))
        else $error("pass_char set on a non-pass command");
    a_cursor_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_action != ACT_CURSOR) |-> (r_row == 8'd0 && r_col == 8'd0))
        else $error("cursor fields set on a non-cursor command");
    a_state_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pop |=> $stable(r_phase))
        else $error("sequence phase moved without a byte");

endmodule

`default_nettype wire

@@ verif/terminal_escape_decoder_tb.sv @@
`timescale 1ns / 100ps

module terminal_escape_decoder_tb;

    import tedec_pkg::*;

    localparam int N_ITEMS        = 1450;
    localparam int GAP_MAX        = 13;
    localparam int RX_HOLD_CYCLES = 48;
    localparam int TX_RUSH_ITEMS  = 24;
    localparam int HOLD_AT_ITEM   = 500;
    localparam int PAUSE_AT_ITEM  = 1000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PRINT_CAP      = 50;

    // Sequence phases of the decoder as the predictor tracks them
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_ESC,
        SEQ_CSI,
        SEQ_ROW,
        SEQ_COL,
        SEQ_ATTR
    } t_seq_phase;

    // One display command, as it leaves the block
    typedef struct packed {
        t_action    act;
        logic [7:0] pch;
        logic [7:0] row;
        logic [7:0] col;
    } t_display_cmd;

    // Predict commands from the accepted byte stream and match them against the output
    class t_display_cmd_board;
        t_seq_phase   phase;
        logic [7:0]   row_raw;
        logic [7:0]   csi_row;
        logic [7:0]   csi_col;
        bit           got_semi;
        bit           got_digit;
        t_display_cmd expected_cmds[$];
        int           mismatch_count;
        int           cmd_index;

        function new();
            phase          = SEQ_IDLE;
            row_raw        = '0;
            csi_row        = '0;
            csi_col        = '0;
            got_semi       = 1'b0;
            got_digit      = 1'b0;
            mismatch_count = 0;
            cmd_index      = 0;
        endfunction

        function logic [7:0] sat_digit(logic [7:0] acc, logic [7:0] c);
            int v;
            v = int'(acc) * 10 + int'(c - CHR_ZERO);
            return (v > 255) ? 8'hFF : v[7:0];
        endfunction

        function logic [7:0] one_if_zero(logic [7:0] v);
            return (v == 8'd0) ? 8'd1 : v;
        endfunction

        function t_display_cmd decode_char(logic [7:0] c);
            t_display_cmd cmd;
            cmd     = '0;
            cmd.act = ACT_CONSUMED;
            case (phase)
                SEQ_ESC: begin
                    if (c == CHR_EQ) begin
                        phase = SEQ_ROW;
                    end else if (c == CHR_LBRACK) begin
                        phase = SEQ_CSI;
                    end else if (c == CHR_B) begin
                        cmd.act = ACT_ACCENT;
                        phase   = SEQ_ATTR;
                    end else if (c == CHR_C) begin
                        cmd.act = ACT_NORMAL;
                        phase   = SEQ_ATTR;
                    end else begin
                        cmd.act = ACT_PASS;
                        cmd.pch = c;
                        phase   = SEQ_IDLE;
                    end
                end
                SEQ_ROW: begin
                    row_raw = c;
                    phase   = SEQ_COL;
                end
                SEQ_COL: begin
                    cmd.act = ACT_CURSOR;
                    cmd.row = row_raw - CURSOR_BIAS;
                    cmd.col = c - CURSOR_BIAS;
                    phase   = SEQ_IDLE;
                end
                SEQ_CSI: begin
                    if (c >= CHR_ZERO && c <= CHR_NINE) begin
                        if (got_semi) begin
                            csi_col = sat_digit(csi_col, c);
                        end else begin
                            csi_row = sat_digit(csi_row, c);
                        end
                        got_digit = 1'b1;
                    end else if (c == CHR_SEMI) begin
                        got_semi = 1'b1;
                    end else if (c == CHR_H) begin
                        cmd.act = ACT_CURSOR;
                        if (got_digit || got_semi) begin
                            cmd.row = one_if_zero(csi_row);
                            cmd.col = one_if_zero(csi_col);
                        end else begin
                            cmd.row = 8'd1;
                            cmd.col = 8'd1;
                        end
                        phase = SEQ_IDLE;
                    end else if (c == CHR_J) begin
                        cmd.act = ACT_CLEAR;
                        phase   = SEQ_IDLE;
                    end else if (c == CHR_K) begin
                        cmd.act = ACT_ERASE_EOL;
                        phase   = SEQ_IDLE;
                    end else begin
                        cmd.act = ACT_PASS;
                        cmd.pch = c;
                        phase   = SEQ_IDLE;
                    end
                end
                SEQ_ATTR: begin
                    phase = SEQ_IDLE;
                end
                default: begin
                    phase = SEQ_IDLE;
                    if (c == CHR_BEL) begin
                        cmd.act = ACT_BELL;
                    end else if (c == CHR_SUB) begin
                        cmd.act = ACT_CLEAR;
                    end else if (c == CHR_ESC) begin
                        phase     = SEQ_ESC;
                        row_raw   = '0;
                        csi_row   = '0;
                        csi_col   = '0;
                        got_semi  = 1'b0;
                        got_digit = 1'b0;
                    end else begin
                        cmd.act = ACT_PASS;
                        cmd.pch = c;
                    end
                end
            endcase
            return cmd;
        endfunction

        function void note_char(logic [7:0] c);
            expected_cmds.push_back(decode_char(c));
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < PRINT_CAP) begin
                $display("mismatch at command %0d: %s", cmd_index, msg);
            end
            mismatch_count++;
        endtask

        task check_command(t_display_cmd got);
            t_display_cmd want;
            if (expected_cmds.size() == 0) begin
                report_mismatch($sformatf("unexpected command, action %0d", got.act));
            end else begin
                want = expected_cmds.pop_front();
                if (got.act !== want.act) begin
                    report_mismatch($sformatf("action %0d, want %0d", got.act, want.act));
                end
                if (got.pch !== want.pch) begin
                    report_mismatch($sformatf("pass_char %h, want %h", got.pch, want.pch));
                end
                if (got.row !== want.row) begin
                    report_mismatch($sformatf("cursor_row %0d, want %0d", got.row, want.row));
                end
                if (got.col !== want.col) begin
                    report_mismatch($sformatf("cursor_col %0d, want %0d", got.col, want.col));
                end
            end
            cmd_index++;
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_char_in;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [2:0] o_action;
    logic [7:0] o_pass_char;
    logic [7:0] o_cursor_row;
    logic [7:0] o_cursor_col;

    t_display_cmd_board sb = new();

    // Bytes waiting to be offered, built one sequence at a time
    logic [7:0] char_plan[$];

    // Sender-side pacing: burst mode and a forced rush while the receiver holds off
    bit tx_burst;
    int tx_rush;

    // Raised by the stimulus to ask the receiver for one long hold-off
    bit rx_hold_req;

    int cycle_count;

    terminal_escape_decoder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_in    (i_char_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_action     (o_action),
        .o_pass_char  (o_pass_char),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stop a hung run; a correct run finishes far below this count
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Pick the idle gap before the next byte: none while rushing or in a burst
    function automatic int pick_tx_gap();
        if ($urandom_range(0, 24) == 0) begin
            tx_burst = !tx_burst;
        end
        if (tx_rush > 0) begin
            tx_rush--;
            return 0;
        end
        return tx_burst ? 0 : int'($urandom_range(0, GAP_MAX));
    endfunction

    function automatic void push_digits(int n);
        for (int i = 0; i < n; i++) begin
            char_plan.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    // Append one random sequence: mostly well-formed escapes with random
    // content, plus plain text, lone control bytes and raw noise
    function automatic void plan_random_sequence();
        int kind;
        int term;
        kind = $urandom_range(0, 15);
        if (kind < 2) begin
            char_plan.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 2) begin
            char_plan.push_back($urandom_range(0, 1) ? CHR_BEL : CHR_SUB);
        end else if (kind < 6) begin
            char_plan.push_back(CHR_ESC);
            char_plan.push_back(CHR_EQ);
            char_plan.push_back(8'($urandom_range(0, 255)));
            char_plan.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 11) begin
            char_plan.push_back(CHR_ESC);
            char_plan.push_back(CHR_LBRACK);
            push_digits($urandom_range(0, 4));
            if ($urandom_range(0, 2) != 0) begin
                repeat ($urandom_range(1, 2)) char_plan.push_back(CHR_SEMI);
                push_digits($urandom_range(0, 4));
            end
            // Leave the sequence open now and then, so the next one breaks into it
            term = $urandom_range(0, 9);
            if (term < 6) begin
                char_plan.push_back(CHR_H);
            end else if (term == 6) begin
                char_plan.push_back(CHR_J);
            end else if (term == 7) begin
                char_plan.push_back(CHR_K);
            end else if (term == 8) begin
                char_plan.push_back(8'($urandom_range(0, 255)));
            end
        end else if (kind < 13) begin
            char_plan.push_back(CHR_ESC);
            char_plan.push_back($urandom_range(0, 1) ? CHR_B : CHR_C);
            char_plan.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 13) begin
            char_plan.push_back(CHR_ESC);
            char_plan.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 6)) char_plan.push_back(8'($urandom_range(32, 126)));
        end
    endfunction

    // Offer one byte and hold it until the input transaction completes.
    // Valid stays high across back-to-back bytes; only a gap drops it.
    task automatic send_char(input logic [7:0] c, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in  <= c;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_char(c);
    endtask

    // Drop valid and wait until every predicted command has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Receiver: draw a stall per command, take the long hold-off when asked,
    // and check each output transaction against the oldest prediction
    initial begin : rx_side
        int           gap;
        bit           rx_burst;
        t_display_cmd got;
        i_out_ready <= 1'b0;
        rx_burst = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                // Hold off long enough for the queue to fill and stall the input
                rx_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                for (int k = 0; k < RX_HOLD_CYCLES; k++) @(posedge i_clk);
            end else begin
                if ($urandom_range(0, 29) == 0) begin
                    rx_burst = !rx_burst;
                end
                gap = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got.act = t_action'(o_action);
            got.pch = o_pass_char;
            got.row = o_cursor_row;
            got.col = o_cursor_col;
            sb.check_command(got);
        end
    end

    // Stimulus: reset, a directed opening, then random sequences
    initial begin : tx_side
        int sent;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_char_in   <= '0;
        tx_burst    = 1'b0;
        tx_rush     = 0;
        rx_hold_req = 1'b0;
        sent        = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: bell, clear, raw cursor at byte extremes, both
        // attributes with an ESC and a 0xFF as the swallowed byte, CSI home,
        // saturated row with repeated separators and missing column, erase
        // to end of line, unknown bytes after ESC and after CSI, and a
        // control byte passing through in idle
        char_plan = {CHR_BEL, CHR_SUB, 8'h08,
                     CHR_ESC, CHR_EQ, 8'h00, 8'hFF,
                     CHR_ESC, CHR_B, CHR_ESC,
                     CHR_ESC, CHR_C, 8'hFF,
                     CHR_ESC, CHR_LBRACK, CHR_H,
                     CHR_ESC, CHR_LBRACK, CHR_NINE, CHR_NINE, CHR_NINE,
                     CHR_SEMI, CHR_SEMI, CHR_H,
                     CHR_ESC, CHR_LBRACK, CHR_K,
                     CHR_ESC, CHR_ESC,
                     CHR_ESC, CHR_LBRACK, 8'h78};

        while (sent < N_ITEMS || char_plan.size() != 0) begin
            if (char_plan.size() == 0) begin
                plan_random_sequence();
            end
            if (sent == HOLD_AT_ITEM) begin
                // Keep offering back to back while the receiver holds off
                rx_hold_req = 1'b1;
                tx_rush     = TX_RUSH_ITEMS;
            end
            if (sent == PAUSE_AT_ITEM) begin
                wait_drained();
            end
            send_char(char_plan.pop_front(), pick_tx_gap());
            sent++;
        end

        wait_drained();
        // Allow for any stray command still in the pipeline
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ terminal_escape_decoder.f @@
rtl/tedec_pkg.sv
rtl/tedec_front.sv
rtl/tedec_queue.sv
rtl/tedec_back.sv
rtl/terminal_escape_decoder.sv
verif/terminal_escape_decoder_tb.sv
